// ----- sv/smlp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smlp_pkg: shared constants, types and helper
// Field widths, stream packing and the saturation helper used by the
// minimum-length spring projection pipeline.
// ----------------------------------------------------------------------------
package smlp_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;

    localparam int unsigned POS_W    = 32;
    localparam int unsigned WGT_W    = 32;
    localparam int unsigned LEN_W    = 31;
    localparam int unsigned DIST_W   = 33;
    localparam int unsigned AXIS_W   = 31;
    localparam int unsigned SQ_W     = 62;
    localparam int unsigned SUM_SQ_W = 64;
    localparam int unsigned ROOT_W   = SUM_SQ_W / 2;
    localparam int unsigned WSUM_W   = WGT_W + 1;
    localparam int unsigned FRAC_Q_W = WGT_W + 1;
    localparam int unsigned RATIO_W  = 39;
    localparam int unsigned MAG_W    = RATIO_W + 1;
    localparam int unsigned STEP_W   = MAG_W + 1;
    localparam int unsigned SUM_W    = 43;

    localparam int unsigned S_TDATA_W = 320;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 192;
    localparam int unsigned M_TUSER_W = 2;

    typedef struct packed {
        logic       move;
        logic       degen;
        logic       start_pin;
        logic       end_pin;
        logic [2:0] neg;
    } t_ctrl;

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed({{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}});
        lo = $signed({{(SUM_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}});
        if (v > hi) begin
            sat_pos = 32'h7FFF_FFFF;
        end else if (v < lo) begin
            sat_pos = 32'h8000_0000;
        end else begin
            sat_pos = v[POS_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/smlp_delay.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smlp_delay: stallable delay line
// Shifts a word through a register chain that advances only while enabled, to line it up with a parallel unit.
// ----------------------------------------------------------------------------
module smlp_delay #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_ce,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    generate
        if (DEPTH == 0) begin : g_none
            assign o_q = i_d;
        end else begin : g_line
            logic [W-1:0] r_line [DEPTH];
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_line[0] <= i_d;
                    for (int k = 1; k < DEPTH; k++) begin
                        r_line[k] <= r_line[k-1];
                    end
                end
            end
            assign o_q = r_line[DEPTH-1];
        end
    endgenerate
endmodule
`default_nettype wire

// ----- sv/smlp_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smlp_div: pipelined restoring divider
// One quotient bit per stage, Q_W stages. The caller guarantees that the
// numerator shifted down by Q_W is below the divisor.
// ----------------------------------------------------------------------------
module smlp_div #(
    parameter int unsigned N_W = 64,
    parameter int unsigned D_W = 32,
    parameter int unsigned Q_W = 32
) (
    input  logic           i_clk,
    input  logic           i_ce,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic [Q_W-1:0] o_quo
);
    logic [D_W-1:0] r_rem [Q_W];
    logic [N_W-1:0] r_num [Q_W];
    logic [D_W-1:0] r_den [Q_W];
    logic [Q_W-1:0] r_quo [Q_W];

    genvar g;
    generate
        for (g = 0; g < Q_W; g++) begin : g_stage
            logic [D_W-1:0] w_rem;
            logic [N_W-1:0] w_num;
            logic [D_W-1:0] w_den;
            logic [Q_W-1:0] w_quo;
            logic [D_W:0]   trial;
            logic [D_W:0]   sub;
            logic           take;

            if (g == 0) begin : g_first
                assign w_rem = D_W'(i_num >> Q_W);
                assign w_num = i_num;
                assign w_den = i_den;
                assign w_quo = '0;
            end else begin : g_next
                assign w_rem = r_rem[g-1];
                assign w_num = r_num[g-1];
                assign w_den = r_den[g-1];
                assign w_quo = r_quo[g-1];
            end

            assign trial = {w_rem, w_num[Q_W-1-g]};
            assign sub   = trial - {1'b0, w_den};
            assign take  = trial >= {1'b0, w_den};

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[g] <= take ? sub[D_W-1:0] : trial[D_W-1:0];
                    r_num[g] <= w_num;
                    r_den[g] <= w_den;
                    r_quo[g] <= w_quo | (take ? (Q_W'(1) << (Q_W-1-g)) : '0);
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[Q_W-1];
endmodule
`default_nettype wire

// ----- sv/smlp_isqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smlp_isqrt: pipelined integer square root
// Digit-by-digit floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module smlp_isqrt (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic [smlp_pkg::SUM_SQ_W-1:0] i_val,
    output logic [smlp_pkg::ROOT_W-1:0]   o_root
);
    import smlp_pkg::*;

    logic [SUM_SQ_W-1:0] r_val  [ROOT_W];
    logic [SUM_SQ_W-1:0] r_root [ROOT_W];

    genvar g;
    generate
        for (g = 0; g < ROOT_W; g++) begin : g_stage
            localparam logic [SUM_SQ_W-1:0] BIT = SUM_SQ_W'(1) << (2 * (ROOT_W - 1 - g));
            logic [SUM_SQ_W-1:0] w_val;
            logic [SUM_SQ_W-1:0] w_root;
            logic [SUM_SQ_W-1:0] trial;
            logic                take;

            if (g == 0) begin : g_first
                assign w_val  = i_val;
                assign w_root = '0;
            end else begin : g_next
                assign w_val  = r_val[g-1];
                assign w_root = r_root[g-1];
            end

            assign trial = w_root + BIT;
            assign take  = w_val >= trial;

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_val[g]  <= take ? w_val - trial : w_val;
                    r_root[g] <= take ? (w_root >> 1) + BIT : w_root >> 1;
                end
            end
        end
    endgenerate

    assign o_root = r_root[ROOT_W-1][ROOT_W-1:0];
endmodule
`default_nettype wire

// ----- sv/spring_min_length_projection.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spring_min_length_projection: minimum-length spring projection
// Pushes the two nodes of a too-short spring apart along its direction.
//
// Input stream carries one spring per transfer (positions, inverse masses,
// stored and minimum length in tdata, pin flags in tuser). Output stream
// carries one result per spring: corrected positions in tdata, adjusted and
// degenerate flags in tuser.
// The direction path runs through a 32-stage square root followed by a
// FRAC_BITS+1 stage direction divider. A new spring is taken every cycle
// while the output is not held by the receiver.
// The whole pipeline advances together; while the output waits on the
// receiver, tready drops and every stage holds, so nothing is lost or
// repeated. Empty stages still fill while the output register is free.
// Reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module spring_min_length_projection #(
    parameter int unsigned FRAC_BITS = smlp_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, start_weight,
    // end_weight, current_length, min_length, zero pad
    input  logic [smlp_pkg::S_TDATA_W-1:0] i_s_tdata,
    // start_pinned, end_pinned
    input  logic [smlp_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // new_start_x, new_start_y, new_start_z, new_end_x, new_end_y, new_end_z
    output logic [smlp_pkg::M_TDATA_W-1:0] o_m_tdata,
    // adjusted, degenerate
    output logic [smlp_pkg::M_TUSER_W-1:0] o_m_tuser
);
    import smlp_pkg::*;

    localparam int unsigned T_U     = 37 + FRAC_BITS;
    localparam int unsigned PIPE_N  = T_U + 3;
    localparam int unsigned NUM_W   = LEN_W + FRAC_BITS;
    localparam int unsigned OVF_SH  = RATIO_W - FRAC_BITS;
    localparam int unsigned U_W     = FRAC_BITS + 1;
    localparam int unsigned PROD_W  = MAG_W + U_W;
    localparam int unsigned POS6_W  = 6 * POS_W;
    localparam int unsigned CTRL_W  = $bits(t_ctrl);

    logic              ce;
    logic [PIPE_N-1:0] r_vld;

    assign ce         = !r_vld[PIPE_N-1] || i_m_tready;
    assign o_s_tready = ce;
    assign o_m_tvalid = r_vld[PIPE_N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[PIPE_N-2:0], i_s_tvalid};
        end
    end

    // stage A: capture the transfer
    logic [S_TDATA_W-1:0] r_a_data;
    logic [S_TUSER_W-1:0] r_a_user;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a_data <= i_s_tdata;
            r_a_user <= i_s_tuser;
        end
    end

    logic [WGT_W-1:0] a_sw, a_ew;
    logic [LEN_W-1:0] a_len, a_min;
    assign a_sw  = r_a_data[6*POS_W +: WGT_W];
    assign a_ew  = r_a_data[6*POS_W+WGT_W +: WGT_W];
    assign a_len = r_a_data[6*POS_W+2*WGT_W +: LEN_W];
    assign a_min = r_a_data[6*POS_W+2*WGT_W+LEN_W +: LEN_W];

    // stage B: differences, case flags, weight sum
    logic [DIST_W-1:0] b_abs [3];
    logic [2:0]        b_neg;
    logic              b_zero;
    t_ctrl             b_ctrl;

    always_comb begin
        logic signed [DIST_W-1:0] d;
        logic                     short_len;
        logic                     degen;
        b_zero = 1'b1;
        for (int k = 0; k < 3; k++) begin
            d = $signed({r_a_data[(3+k)*POS_W+POS_W-1], r_a_data[(3+k)*POS_W +: POS_W]})
              - $signed({r_a_data[k*POS_W+POS_W-1], r_a_data[k*POS_W +: POS_W]});
            b_neg[k] = d[DIST_W-1];
            b_abs[k] = d[DIST_W-1] ? DIST_W'(-d) : DIST_W'(d);
            if (d != '0) begin
                b_zero = 1'b0;
            end
        end
        short_len = a_len < a_min;
        degen     = short_len && (a_len == '0 || (a_sw == '0 && a_ew == '0) || b_zero);
        b_ctrl.degen     = degen;
        b_ctrl.move      = short_len && !degen && !(r_a_user[0] && r_a_user[1]);
        b_ctrl.start_pin = r_a_user[0];
        b_ctrl.end_pin   = r_a_user[1];
        b_ctrl.neg       = b_neg;
    end

    logic [DIST_W-1:0] r_b_abs [3];
    logic [WSUM_W-1:0] r_b_wsum;
    logic [LEN_W-1:0]  r_b_diff, r_b_len;
    logic [WGT_W-1:0]  r_b_sw, r_b_ew;
    t_ctrl             r_b_ctrl;
    logic [POS6_W-1:0] r_b_pos;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_b_abs  <= b_abs;
            r_b_wsum <= WSUM_W'(a_sw) + WSUM_W'(a_ew);
            r_b_diff <= a_min - a_len;
            r_b_len  <= a_len;
            r_b_sw   <= a_sw;
            r_b_ew   <= a_ew;
            r_b_ctrl <= b_ctrl;
            r_b_pos  <= r_a_data[POS6_W-1:0];
        end
    end

    // stage C: scale the direction into 31 bits, check ratio overflow
    logic [AXIS_W-1:0] c_a [3];

    always_comb begin
        logic [DIST_W-1:0] m;
        logic [1:0]        s;
        m = r_b_abs[0];
        if (r_b_abs[1] > m) m = r_b_abs[1];
        if (r_b_abs[2] > m) m = r_b_abs[2];
        if (m[DIST_W-1]) begin
            s = 2'd2;
        end else if (m[DIST_W-2]) begin
            s = 2'd1;
        end else begin
            s = 2'd0;
        end
        for (int k = 0; k < 3; k++) begin
            c_a[k] = AXIS_W'(r_b_abs[k] >> s);
        end
    end

    logic [AXIS_W-1:0] r_c_a [3];
    logic              r_c_ovf;
    logic [LEN_W-1:0]  r_c_diff, r_c_len;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_c_a    <= c_a;
            r_c_ovf  <= (r_b_diff >> OVF_SH) >= r_b_len;
            r_c_diff <= r_b_diff;
            r_c_len  <= r_b_len;
        end
    end

    // stage D and E: sum of squares
    logic [SQ_W-1:0]     r_d_sq [3];
    logic [SUM_SQ_W-1:0] r_e_sum;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                r_d_sq[k] <= SQ_W'(r_c_a[k]) * SQ_W'(r_c_a[k]);
            end
            r_e_sum <= SUM_SQ_W'(r_d_sq[0]) + SUM_SQ_W'(r_d_sq[1]) + SUM_SQ_W'(r_d_sq[2]);
        end
    end

    logic [ROOT_W-1:0] root;

    smlp_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_val  (r_e_sum),
        .o_root (root)
    );

    // unit direction, one divider per axis
    logic [3*AXIS_W-1:0] a_dly;
    logic [U_W-1:0]      u_vec [3];

    smlp_delay #(.W(3*AXIS_W), .DEPTH(ROOT_W + 2)) u_a_dly (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_d   ({r_c_a[2], r_c_a[1], r_c_a[0]}),
        .o_q   (a_dly)
    );

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_udiv
            smlp_div #(.N_W(NUM_W), .D_W(ROOT_W), .Q_W(U_W)) u_div (
                .i_clk (i_clk),
                .i_ce  (ce),
                .i_num (NUM_W'(a_dly[g*AXIS_W +: AXIS_W]) << FRAC_BITS),
                .i_den (root),
                .o_quo (u_vec[g])
            );
        end
    endgenerate

    // length ratio and weight fractions
    logic [RATIO_W-1:0]  ratio_q;
    logic                ovf_dly;
    logic [FRAC_Q_W-1:0] sfrac_q, efrac_q, sfrac, efrac;

    smlp_div #(.N_W(NUM_W), .D_W(LEN_W), .Q_W(RATIO_W)) u_ratio_div (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (NUM_W'(r_c_diff) << FRAC_BITS),
        .i_den (r_c_len),
        .o_quo (ratio_q)
    );

    smlp_delay #(.W(1), .DEPTH(RATIO_W)) u_ovf_dly (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_d   (r_c_ovf),
        .o_q   (ovf_dly)
    );

    smlp_div #(.N_W(2*WGT_W), .D_W(WSUM_W), .Q_W(FRAC_Q_W)) u_sfrac_div (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num ({r_b_sw, {WGT_W{1'b0}}}),
        .i_den (r_b_wsum),
        .o_quo (sfrac_q)
    );

    smlp_div #(.N_W(2*WGT_W), .D_W(WSUM_W), .Q_W(FRAC_Q_W)) u_efrac_div (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num ({r_b_ew, {WGT_W{1'b0}}}),
        .i_den (r_b_wsum),
        .o_quo (efrac_q)
    );

    smlp_delay #(.W(2*FRAC_Q_W), .DEPTH(RATIO_W + 1 - FRAC_Q_W)) u_frac_dly (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_d   ({efrac_q, sfrac_q}),
        .o_q   ({efrac, sfrac})
    );

    // stage M1 and M2: per-node move magnitude
    logic [RATIO_W-1:0] ratio;
    assign ratio = ovf_dly ? '1 : ratio_q;

    logic [MAG_W-1:0]           r_m1_shi, r_m1_ehi;
    logic [WGT_W+FRAC_Q_W-1:0]  r_m1_slo, r_m1_elo;
    logic [MAG_W-1:0]           r_m2_smag, r_m2_emag;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_m1_shi  <= MAG_W'(ratio[RATIO_W-1:WGT_W]) * MAG_W'(sfrac);
            r_m1_ehi  <= MAG_W'(ratio[RATIO_W-1:WGT_W]) * MAG_W'(efrac);
            r_m1_slo  <= (WGT_W+FRAC_Q_W)'(ratio[WGT_W-1:0]) * (WGT_W+FRAC_Q_W)'(sfrac);
            r_m1_elo  <= (WGT_W+FRAC_Q_W)'(ratio[WGT_W-1:0]) * (WGT_W+FRAC_Q_W)'(efrac);
            r_m2_smag <= r_m1_shi + MAG_W'(r_m1_slo >> WGT_W);
            r_m2_emag <= r_m1_ehi + MAG_W'(r_m1_elo >> WGT_W);
        end
    end

    logic [MAG_W-1:0] smag, emag;

    smlp_delay #(.W(2*MAG_W), .DEPTH(T_U - 43)) u_mag_dly (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_d   ({r_m2_emag, r_m2_smag}),
        .o_q   ({emag, smag})
    );

    // sideband: positions and case flags
    logic [POS6_W-1:0] pos_dly;
    logic [CTRL_W-1:0] ctrl_dly_v;
    t_ctrl             ctrl_dly;

    smlp_delay #(.W(POS6_W + CTRL_W), .DEPTH(T_U - 1)) u_side_dly (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_d   ({r_b_ctrl, r_b_pos}),
        .o_q   ({ctrl_dly_v, pos_dly})
    );
    assign ctrl_dly = t_ctrl'(ctrl_dly_v);

    // stage P: per-axis steps
    logic [STEP_W-1:0] p_st [3];
    logic [STEP_W-1:0] p_et [3];

    always_comb begin
        logic [PROD_W-1:0] ps;
        logic [PROD_W-1:0] pe;
        for (int k = 0; k < 3; k++) begin
            ps = PROD_W'(smag) * PROD_W'(u_vec[k]);
            pe = PROD_W'(emag) * PROD_W'(u_vec[k]);
            p_st[k] = STEP_W'(ps >> FRAC_BITS);
            p_et[k] = STEP_W'(pe >> FRAC_BITS);
        end
    end

    logic [STEP_W-1:0] r_p_st [3];
    logic [STEP_W-1:0] r_p_et [3];
    logic [POS6_W-1:0] r_p_pos;
    t_ctrl             r_p_ctrl;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_p_st   <= p_st;
            r_p_et   <= p_et;
            r_p_pos  <= pos_dly;
            r_p_ctrl <= ctrl_dly;
        end
    end

    // output stage: apply steps and saturate
    logic [M_TDATA_W-1:0] o_data;

    always_comb begin
        logic signed [SUM_W-1:0] sp;
        logic signed [SUM_W-1:0] ep;
        logic signed [SUM_W-1:0] st;
        logic signed [SUM_W-1:0] et;
        logic signed [SUM_W-1:0] ns;
        logic signed [SUM_W-1:0] ne;
        o_data = r_p_pos;
        for (int k = 0; k < 3; k++) begin
            sp = SUM_W'($signed(r_p_pos[k*POS_W +: POS_W]));
            ep = SUM_W'($signed(r_p_pos[(3+k)*POS_W +: POS_W]));
            st = $signed(SUM_W'(r_p_st[k]));
            et = $signed(SUM_W'(r_p_et[k]));
            // start moves against the direction, end with it
            ns = r_p_ctrl.neg[k] ? sp + st : sp - st;
            ne = r_p_ctrl.neg[k] ? ep - et : ep + et;
            if (r_p_ctrl.move && !r_p_ctrl.start_pin) begin
                o_data[k*POS_W +: POS_W] = sat_pos(ns);
            end
            if (r_p_ctrl.move && !r_p_ctrl.end_pin) begin
                o_data[(3+k)*POS_W +: POS_W] = sat_pos(ne);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            o_m_tdata <= o_data;
            o_m_tuser <= {r_p_ctrl.degen, r_p_ctrl.move};
        end
    end

endmodule
`default_nettype wire

// ----- verif/smlp_checker.sv -----
// ----------------------------------------------------------------------------
// smlp_checker: result predictor and comparator
// Watches both stream channels of the spring projection block, computes the
// expected corrected positions and flags for every accepted spring and
// compares each output transfer against the oldest pending expectation.
// ----------------------------------------------------------------------------
module smlp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [smlp_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [smlp_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [smlp_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic [smlp_pkg::M_TUSER_W-1:0] i_m_tuser,
    output int                             o_fail_count,
    output int                             o_pending
);
    import smlp_pkg::*;

    typedef struct {
        logic [M_TDATA_W-1:0] pos;
        logic [M_TUSER_W-1:0] flags;
    } t_result;

    t_result pending_results[$];

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_result project_spring(input logic [S_TDATA_W-1:0] d,
                                               input logic [S_TUSER_W-1:0] pins);
        t_result   res;
        longint    sp[3];
        longint    ep[3];
        longint    ns[3];
        longint    ne[3];
        longint    diff;
        logic [63:0] sw, ew, wsum, len, mn, m, sum, n, ratio, smag, emag, sfrac, efrac;
        logic [63:0] mag3[3];
        logic [63:0] u[3];
        logic [127:0] prod;
        logic      neg[3];
        logic      adj, degen;
        int        shift;
        longint    st, et;
        for (int i = 0; i < 3; i++) begin
            sp[i] = longint'($signed(d[32*i +: 32]));
            ep[i] = longint'($signed(d[32*(3+i) +: 32]));
            ns[i] = sp[i];
            ne[i] = ep[i];
        end
        sw  = 64'(d[192 +: 32]);
        ew  = 64'(d[224 +: 32]);
        len = 64'(d[256 +: 31]);
        mn  = 64'(d[287 +: 31]);
        adj = 0;
        degen = 0;
        if (len < mn) begin
            wsum = sw + ew;
            m = 0;
            for (int i = 0; i < 3; i++) begin
                diff = ep[i] - sp[i];
                neg[i] = diff < 0;
                mag3[i] = neg[i] ? 64'(-diff) : 64'(diff);
                if (mag3[i] > m) m = mag3[i];
            end
            if (len == 0 || wsum == 0 || m == 0) begin
                degen = 1;
            end else if (!(pins[0] && pins[1])) begin
                shift = 0;
                while ((m >> shift) >= 64'h8000_0000) shift++;
                sum = 0;
                for (int i = 0; i < 3; i++) begin
                    mag3[i] = mag3[i] >> shift;
                    sum += mag3[i] * mag3[i];
                end
                n = isqrt(sum);
                for (int i = 0; i < 3; i++) u[i] = (mag3[i] << FRAC_BITS_DEF) / n;
                ratio = ((mn - len) << FRAC_BITS_DEF) / len;
                if (ratio > (64'd1 << 39) - 1) ratio = (64'd1 << 39) - 1;
                sfrac = (sw << 32) / wsum;
                efrac = (ew << 32) / wsum;
                prod = 128'(ratio) * 128'(sfrac);
                smag = 64'(prod >> 32);
                prod = 128'(ratio) * 128'(efrac);
                emag = 64'(prod >> 32);
                for (int i = 0; i < 3; i++) begin
                    prod = 128'(smag) * 128'(u[i]);
                    st = longint'(prod >> FRAC_BITS_DEF);
                    prod = 128'(emag) * 128'(u[i]);
                    et = longint'(prod >> FRAC_BITS_DEF);
                    if (neg[i]) begin
                        st = -st;
                        et = -et;
                    end
                    if (!pins[0]) ns[i] = sp[i] - st;
                    if (!pins[1]) ne[i] = ep[i] + et;
                end
                adj = 1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            res.pos[32*i +: 32]     = clamp32(ns[i]);
            res.pos[32*(3+i) +: 32] = clamp32(ne[i]);
        end
        res.flags = {degen, adj};
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                pending_results.push_back(project_spring(i_s_tdata, i_s_tuser));
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result %h", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (want.pos !== i_m_tdata || want.flags !== i_m_tuser) begin
                        if (o_fail_count < 10) begin
                            for (int i = 0; i < 6; i++)
                                if (want.pos[32*i +: 32] !== i_m_tdata[32*i +: 32])
                                    $display("position %0d: expected %h got %h", i,
                                             want.pos[32*i +: 32], i_m_tdata[32*i +: 32]);
                            if (want.flags !== i_m_tuser)
                                $display("flags {degenerate,adjusted}: expected %b got %b",
                                         want.flags, i_m_tuser);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= pending_results.size();
        end
    end

endmodule

// ----- verif/tb_spring_min_length_projection.sv -----
// ----------------------------------------------------------------------------
// tb_spring_min_length_projection: spring projection testbench
// Drives directed and random springs under several idling phases, including
// a long receiver hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_spring_min_length_projection;
    import smlp_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    int                   fail_count;
    int                   pending;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   holdoff_cycles;
    longint               cycle_count;

    spring_min_length_projection uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    smlp_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("spring_min_length_projection verification failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long hold-off counted here
    initial begin
        m_tready = 0;
        forever begin
            @(posedge i_clk);
            if (holdoff_cycles > 0) begin
                holdoff_cycles <= holdoff_cycles - 1;
                m_tready <= 0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF - $urandom_range(3);
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return $urandom_range(2000) - 1000;
            3: return ($urandom_range(4000) - 2000) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(4))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_spring(input logic [31:0] sx, sy, sz, ex, ey, ez, sw, ew,
                               input logic [1:0] pins, input logic [30:0] len, mn);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {2'b0, mn, len, ew, sw, ez, ey, ex, sz, sy, sx};
        s_tuser  <= pins;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic [30:0] len, mn;
        logic [31:0] sx, sy, sz;
        len = 31'($urandom);
        mn = 31'($urandom);
        if ($urandom_range(3) != 0) begin
            // mostly too-short springs so the correction path is exercised
            if ($urandom_range(1)) len = 31'($urandom_range(65536 * 8));
            if (mn <= len) mn = 31'(len + $urandom_range(1 << 20) + 1);
        end
        if ($urandom_range(9) == 0) len = 31'd0;
        sx = rand_coord();
        sy = rand_coord();
        sz = rand_coord();
        if ($urandom_range(15) == 0)
            send_spring(sx, sy, sz, sx, sy, sz, rand_weight(), rand_weight(),
                        2'($urandom), len, mn);
        else
            send_spring(sx, sy, sz, rand_coord(), rand_coord(), rand_coord(),
                        rand_weight(), rand_weight(), 2'($urandom), len, mn);
    endtask

    initial begin
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        i_rst_n = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        holdoff_cycles = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: pass-through, degenerate cases, pins, extremes
        send_spring(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 2'b00, 31'h20000, 31'h10000);
        send_spring(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 2'b00, 31'd0, 31'h10000);
        send_spring(0, 0, 0, 32'h10000, 0, 0, 0, 0, 2'b00, 31'h8000, 31'h10000);
        send_spring(5, 6, 7, 5, 6, 7, 32'h10000, 32'h10000, 2'b00, 31'h8000, 31'h10000);
        send_spring(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 2'b11, 31'h8000, 31'h10000);
        send_spring(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 2'b01, 31'h8000, 31'h10000);
        send_spring(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 2'b10, 31'h8000, 31'h10000);
        send_spring(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 2'b00,
                    31'h1_0000, 31'h1_0001);
        send_spring(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b00, 31'd1, 31'h7FFF_FFFF);
        send_spring(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'hFFFF_FFFF, 0, 2'b00, 31'd1, 31'h7FFF_FFFF);
        send_spring(0, 0, 0, 32'hFFFF_0000, 32'h10000, 0, 1, 32'hFFFF_FFFF, 2'b00, 31'h7FFF_FFFE,
                    31'h7FFF_FFFF);
        send_spring(100, -200, 300, 100, -200, 301, 0, 32'h10000, 2'b00, 31'h100, 31'h200);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                3: begin send_idle_pct = 10; recv_stall_pct = 10; end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    holdoff_cycles = 300;
                end
            endcase
            repeat (130) send_random();
        end
        s_tvalid <= 0;
        recv_stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("spring_min_length_projection verification clean");
        else
            $display("spring_min_length_projection verification failed");
        $finish;
    end

endmodule
